// ----- rtl/rrus_pkg.sv -----
// shared types, constants and register codes for the round-robin unit stager
// no dependencies; imported by every rtl module of the block
`default_nettype none

package rrus_pkg;

    localparam int MAX_UNITS = 8;
    localparam int UNIT_W    = $clog2(MAX_UNITS);
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);
    localparam int MASK_W    = 8;
    localparam int UCFG_W    = 4;
    localparam int ELAPSED_W = 10;
    localparam int LEN_W     = 24;
    localparam int TMR_W     = 25;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ILK_SINGLE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ILK_ALL_MS    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ILK_END  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STARTING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STOPPING = 3'd4;

    localparam logic [UCFG_W-1:0] UNIT_COUNT_RST = UCFG_W'(8);

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 all_start;
        logic                 all_stop;
        logic                 more_request;
        logic                 less_request;
        logic                 start_enable;
        logic [MASK_W-1:0]    on_mask;
        logic [MASK_W-1:0]    ready_mask;
        logic [MASK_W-1:0]    interlocked_mask;
        logic [MASK_W-1:0]    fault_mask;
    } scan_t;

    typedef struct packed {
        logic                cmd_valid;
        logic [2:0]          cmd_unit;
        logic                cmd_run;
        logic [STATUS_W-1:0] status_code;
    } result_t;

    // per-unit status bits handed to one lane
    typedef struct packed {
        logic on;
        logic ready;
        logic ilk;
        logic flt;
    } unit_status_t;

    typedef struct packed {
        logic [UNIT_W-1:0] start_ptr;
        logic [UNIT_W-1:0] stop_ptr;
        logic [CNT_W-1:0]  n_units;
    } search_ctl_t;

    typedef struct packed {
        logic start_hit;
        logic stop_hit;
    } lane_hit_t;

    typedef struct packed {
        logic              start_found;
        logic [UNIT_W-1:0] start_unit;
        logic [UNIT_W-1:0] start_ptr_next;
        logic              stop_found;
        logic [UNIT_W-1:0] stop_unit;
        logic [UNIT_W-1:0] stop_ptr_next;
    } search_res_t;

endpackage

`default_nettype wire

// ----- rtl/rrus_lane.sv -----
// one unit lane: checks start and stop eligibility of its unit inside the search window
// depends on rrus_pkg
`default_nettype none

module rrus_lane
    import rrus_pkg::*;
(
    input  wire logic [UNIT_W-1:0] lane_idx,
    input  wire unit_status_t      status,
    input  wire search_ctl_t       ctl,
    output lane_hit_t              hit
);

    logic in_range;

    assign in_range = ({1'b0, lane_idx} < ctl.n_units);

    assign hit.start_hit = in_range && (lane_idx >= ctl.start_ptr)
                           && !status.on && status.ready && !status.ilk && !status.flt;
    assign hit.stop_hit  = in_range && (lane_idx >= ctl.stop_ptr)
                           && status.on && status.ready;

endmodule

`default_nettype wire

// ----- rtl/rrus_merge.sv -----
// merges lane hits: lowest hit wins for start and stop, next pointer values
// depends on rrus_pkg
`default_nettype none

module rrus_merge
    import rrus_pkg::*;
(
    input  wire lane_hit_t   hits [MAX_UNITS],
    input  wire search_ctl_t ctl,
    output search_res_t      res
);

    logic              start_found;
    logic [UNIT_W-1:0] start_unit;
    logic              stop_found;
    logic [UNIT_W-1:0] stop_unit;
    logic [CNT_W-1:0]  start_inc;
    logic [CNT_W-1:0]  stop_inc;

    always_comb
    begin
        start_found = 1'b0;
        start_unit  = '0;
        stop_found  = 1'b0;
        stop_unit   = '0;
        // walk down so the lowest index ends up selected
        for (int i = MAX_UNITS - 1; i >= 0; i--)
        begin
            if (hits[i].start_hit)
            begin
                start_found = 1'b1;
                start_unit  = UNIT_W'(i);
            end
            if (hits[i].stop_hit)
            begin
                stop_found = 1'b1;
                stop_unit  = UNIT_W'(i);
            end
        end
    end

    assign start_inc = {1'b0, start_unit} + CNT_W'(1);
    assign stop_inc  = {1'b0, stop_unit} + CNT_W'(1);

    assign res.start_found    = start_found;
    assign res.start_unit     = start_unit;
    assign res.start_ptr_next = (start_found && (start_inc < ctl.n_units))
                                ? start_inc[UNIT_W-1:0] : '0;
    assign res.stop_found     = stop_found;
    assign res.stop_unit      = stop_unit;
    assign res.stop_ptr_next  = (stop_found && (stop_inc < ctl.n_units))
                                ? stop_inc[UNIT_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/round_robin_unit_stager_top.sv -----
// a scan's result is registered in the output register, or in the skid entry under stall
// throughput: one scan per cycle while scan_stall is low; the pointer/timer update (timer
//   add, lane search, merge) is combinational; a full two-entry output buffer stalls scans
// reset: asynchronous, clears pointers, timer, status and buffer, loads config defaults
// no clearing pass after reset
// top level of the round-robin unit stager: config, timer, state, lanes and output buffer
// depends on rrus_pkg, rrus_lane, rrus_merge
`default_nettype none

module round_robin_unit_stager_top
    import rrus_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 scan_valid,
    output logic                      scan_stall,
    input  wire scan_t                scan,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    logic [UCFG_W-1:0]   unit_count_reg;
    logic [LEN_W-1:0]    ilk_single_reg;
    logic [LEN_W-1:0]    ilk_all_reg;
    logic [UNIT_W-1:0]   start_ptr_reg, start_ptr_next;
    logic [UNIT_W-1:0]   stop_ptr_reg, stop_ptr_next;
    logic                armed_reg, armed_next;
    logic                fresh_reg, fresh_next;
    logic [TMR_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    result_t             skid_data_reg, skid_data_next;

    logic                scan_accept;
    logic                result_pop;
    logic [CNT_W-1:0]    n_eff;
    logic                all_any;
    logic [LEN_W-1:0]    length;
    logic [TMR_W:0]      count_sum;
    logic [TMR_W-1:0]    count_adv;
    logic                expire;
    logic                start_req;
    logic                stop_req;
    result_t             cmd;

    search_ctl_t         ctl;
    search_res_t         res;
    unit_status_t        lane_status [MAX_UNITS];
    lane_hit_t           lane_hits [MAX_UNITS];

    assign cfg_ready   = 1'b1;
    assign scan_stall  = skid_valid_reg;
    assign scan_accept = scan_valid && !scan_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign result_pop   = out_valid_reg && !result_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg <= UNIT_COUNT_RST;
            ilk_single_reg <= '0;
            ilk_all_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_UNIT_COUNT:    unit_count_reg <= cfg_data[UCFG_W-1:0];
                CFG_ILK_SINGLE_MS: ilk_single_reg <= cfg_data;
                CFG_ILK_ALL_MS:    ilk_all_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign n_eff = ({1'b0, unit_count_reg} > (UCFG_W + 1)'(MAX_UNITS))
                   ? CNT_W'(MAX_UNITS) : CNT_W'(unit_count_reg);

    assign ctl.start_ptr = start_ptr_reg;
    assign ctl.stop_ptr  = stop_ptr_reg;
    assign ctl.n_units   = n_eff;

    for (genvar g = 0; g < MAX_UNITS; g++)
    begin : g_lane
        assign lane_status[g].on    = scan.on_mask[g];
        assign lane_status[g].ready = scan.ready_mask[g];
        assign lane_status[g].ilk   = scan.interlocked_mask[g];
        assign lane_status[g].flt   = scan.fault_mask[g];

        rrus_lane u_lane (
            .lane_idx (UNIT_W'(g)),
            .status   (lane_status[g]),
            .ctl      (ctl),
            .hit      (lane_hits[g])
        );
    end

    rrus_merge u_merge (
        .hits (lane_hits),
        .ctl  (ctl),
        .res  (res)
    );

    // interlock timer advance, saturating
    assign all_any   = scan.all_start || scan.all_stop;
    assign length    = all_any ? ilk_all_reg : ilk_single_reg;
    assign count_sum = {1'b0, count_reg} + (TMR_W + 1)'(scan.elapsed_ms);
    assign count_adv = fresh_reg ? count_reg
                     : (count_sum[TMR_W] ? {TMR_W{1'b1}} : count_sum[TMR_W-1:0]);
    assign expire    = armed_reg && (count_adv > {1'b0, length});
    assign start_req = (scan.more_request || scan.all_start) && scan.start_enable;
    assign stop_req  = scan.less_request || scan.all_stop;

    always_comb
    begin
        start_ptr_next = start_ptr_reg;
        stop_ptr_next  = stop_ptr_reg;
        armed_next     = armed_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        cmd            = '0;

        if (!all_any && !scan.more_request && !scan.less_request)
        begin
            status_next = ST_OK;
        end

        if (armed_reg)
        begin
            fresh_next = 1'b0;
            count_next = count_adv;
            if (expire)
            begin
                armed_next  = 1'b0;
                status_next = ST_ILK_END;
            end
        end

        if (!armed_reg || expire)
        begin
            if (start_req)
            begin
                status_next    = ST_STARTING;
                start_ptr_next = res.start_ptr_next;
                if (res.start_found)
                begin
                    cmd.cmd_valid = 1'b1;
                    cmd.cmd_unit  = 3'(res.start_unit);
                    cmd.cmd_run   = 1'b1;
                end
            end
            if (!cmd.cmd_valid && stop_req)
            begin
                status_next   = ST_STOPPING;
                stop_ptr_next = res.stop_ptr_next;
                if (res.stop_found)
                begin
                    cmd.cmd_valid = 1'b1;
                    cmd.cmd_unit  = 3'(res.stop_unit);
                    cmd.cmd_run   = 1'b0;
                end
            end
            if (cmd.cmd_valid)
            begin
                armed_next = 1'b1;
                fresh_next = 1'b1;
                count_next = '0;
            end
        end
        cmd.status_code = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ptr_reg <= '0;
            stop_ptr_reg  <= '0;
            armed_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
            count_reg     <= '0;
            status_reg    <= ST_NONE;
        end
        else if (scan_accept)
        begin
            start_ptr_reg <= start_ptr_next;
            stop_ptr_reg  <= stop_ptr_next;
            armed_reg     <= armed_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    // two-entry output buffer: output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (result_pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || result_pop)
        begin
            out_valid_next = scan_accept;
            out_data_next  = cmd;
        end
        else if (scan_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_fresh_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> armed_reg)
        else $error("interlock fresh flag set with timer disarmed");

    a_cmd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_accept && cmd.cmd_valid) |-> ({1'b0, cmd.cmd_unit} < n_eff))
        else $error("commanded unit outside rotation");

    a_cmd_arms_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_accept && cmd.cmd_valid) |=> (armed_reg && fresh_reg && (count_reg == '0)))
        else $error("command did not arm the interlock timer");

    a_ptr_moves_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start_ptr_reg != $past(start_ptr_reg)) |-> $past(scan_accept))
        else $error("start pointer moved without a scan transaction");

endmodule

`default_nettype wire
